// File: hdl/pdiw_pkg.sv
// pdiw_pkg: shared constants for the pid dead band / integral window controller
// register indexes, field widths and reset values; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdiw_pkg;

  // field widths
  localparam int SampleW = 16;
  localparam int ErrW    = SampleW + 1;
  localparam int GainW   = 16;
  localparam int BandW   = 16;
  localparam int WinW    = 17;
  localparam int LimW    = 31;
  localparam int DriveW  = 32;
  localparam int AccW    = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 31;

  // fraction bits of the Q8.8 gains
  localparam int FracW = 8;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegGainP   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegGainI   = 3'd1;
  localparam logic [CfgAddrW-1:0] RegGainD   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegDeadBand = 3'd3;
  localparam logic [CfgAddrW-1:0] RegErrWin  = 3'd4;
  localparam logic [CfgAddrW-1:0] RegIntLim  = 3'd5;

  // reset values of the window and the clamp
  localparam logic [WinW-1:0] ErrWinReset = '1;
  localparam logic [LimW-1:0] IntLimReset = '1;

  // results in flight between input and output register
  localparam int PipeDepth = 3;

endpackage

`default_nettype wire

// File: hdl/pid_deadband_integral_window.sv
// pid_deadband_integral_window: positional pid controller with dead band,
// error window and clamped integral; depends on pdiw_pkg
`timescale 1ns / 1ps
`default_nettype none

// throughput: one request per cycle while the output is not stalled;
// the integral add and clamp close in the accept stage, so each request
// sees the integral as left by the last request that acted
// stages: error/window/integral, three products, sum/shift/saturate + output
// reset (rst, synchronous, active high): gains 0, dead band 0, window and
// limit to all ones, last error, integral and held drive 0, pipeline empty
module pid_deadband_integral_window (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [pdiw_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [pdiw_pkg::CfgDataW-1:0] cfg_wdata,
  // request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [15:0] measured, [31:16] target
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,  // [31:0] drive
  output      logic [0:0]  m_axis_tuser   // [0] acted
);

  localparam int SW = pdiw_pkg::SampleW;
  localparam int EW = pdiw_pkg::ErrW;
  localparam int GW = pdiw_pkg::GainW;
  localparam int AW = pdiw_pkg::AccW;
  localparam int DW = pdiw_pkg::DriveW;
  // products and their sum
  localparam int PPW = GW + EW;       // gain_p * e
  localparam int PIW = GW + AW;       // gain_i * integral
  localparam int PDW = GW + EW + 1;   // gain_d * (e - prev)
  localparam int SumW = PIW + 1;
  localparam int ShW = SumW - pdiw_pkg::FracW;

  // configuration registers
  logic signed [GW-1:0] gain_p;
  logic signed [GW-1:0] gain_i;
  logic signed [GW-1:0] gain_d;
  logic [pdiw_pkg::BandW-1:0] dead_band;
  logic [pdiw_pkg::WinW-1:0]  error_window;
  logic [pdiw_pkg::LimW-1:0]  integral_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      dead_band      <= '0;
      error_window   <= pdiw_pkg::ErrWinReset;
      integral_limit <= pdiw_pkg::IntLimReset;
    end else if (cfg_we) begin
      // unknown indexes fall through and are dropped
      unique case (cfg_addr)
        pdiw_pkg::RegGainP:    gain_p         <= cfg_wdata[GW-1:0];
        pdiw_pkg::RegGainI:    gain_i         <= cfg_wdata[GW-1:0];
        pdiw_pkg::RegGainD:    gain_d         <= cfg_wdata[GW-1:0];
        pdiw_pkg::RegDeadBand: dead_band      <= cfg_wdata[pdiw_pkg::BandW-1:0];
        pdiw_pkg::RegErrWin:   error_window   <= cfg_wdata[pdiw_pkg::WinW-1:0];
        pdiw_pkg::RegIntLim:   integral_limit <= cfg_wdata[pdiw_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: each stage moves when it is empty or the next one moves
  logic va, vb;
  logic ready_a, ready_b, ready_c;

  assign ready_c = !m_axis_tvalid || m_axis_tready;
  assign ready_b = !vb || ready_c;
  assign ready_a = !va || ready_b;
  assign s_axis_tready = ready_a;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // stage a: error, window test, integral add and clamp
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] last_error;
  logic signed [AW-1:0] integral;

  logic signed [SW-1:0] measured, target;
  logic signed [EW-1:0] err;
  logic [EW-1:0]        mag;
  logic                 act;
  logic signed [EW:0]   adj;
  logic signed [AW:0]   acc;
  logic signed [AW:0]   lim;
  logic signed [AW-1:0] integral_next;
  logic signed [EW:0]   diff;

  always_comb begin
    measured = s_axis_tdata[SW-1:0];
    target   = s_axis_tdata[2*SW-1:SW];
    err      = EW'(target) - EW'(measured);
    mag      = err[EW-1] ? EW'(-err) : EW'(err);
    act      = (mag > EW'(dead_band)) && (mag < error_window);
    // error moved toward zero by the dead band
    if (err[EW-1] || err == '0) begin
      adj = (EW+1)'(err) + $signed({2'b00, dead_band});
    end else begin
      adj = (EW+1)'(err) - $signed({2'b00, dead_band});
    end
    acc = (AW+1)'(integral) + (AW+1)'(adj);
    lim = $signed({2'b00, integral_limit});
    priority if (acc > lim) begin
      integral_next = AW'(lim);
    end else if (acc < -lim) begin
      integral_next = AW'(-lim);
    end else begin
      integral_next = AW'(acc);
    end
    diff = (EW+1)'(err) - (EW+1)'(last_error);
  end

  logic signed [EW-1:0] err_a;
  logic signed [EW:0]   diff_a;
  logic signed [AW-1:0] integral_a;
  logic                 act_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
      va         <= 1'b0;
    end else begin
      if (accept) begin
        last_error <= err;
        if (act) begin
          integral <= integral_next;
        end
      end
      if (ready_a) begin
        va <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_a      <= err;
      diff_a     <= diff;
      integral_a <= integral_next;
      act_a      <= act;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: the three gain products
  // ---------------------------------------------------------------------
  logic signed [PPW-1:0] prod_p;
  logic signed [PIW-1:0] prod_i;
  logic signed [PDW-1:0] prod_d;
  logic                  act_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      prod_p <= PPW'(gain_p) * PPW'(err_a);
      prod_i <= PIW'(gain_i) * PIW'(integral_a);
      prod_d <= PDW'(gain_d) * PDW'(diff_a);
      act_b  <= act_a;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: sum, arithmetic shift (floor), saturate, output register
  // ---------------------------------------------------------------------
  logic signed [SumW-1:0] sum;
  logic signed [ShW-1:0]  shifted;
  logic signed [DW-1:0]   sat;
  logic signed [DW-1:0]   held_drive;

  localparam logic signed [ShW-1:0] DriveMax = ShW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [ShW-1:0] DriveMin = -DriveMax - ShW'(1);

  always_comb begin
    sum     = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
    shifted = ShW'(sum >>> pdiw_pkg::FracW);
    priority if (shifted > DriveMax) begin
      sat = DW'(DriveMax);
    end else if (shifted < DriveMin) begin
      sat = DW'(DriveMin);
    end else begin
      sat = DW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      held_drive    <= '0;
    end else if (ready_c) begin
      m_axis_tvalid <= vb;
      if (vb && act_b) begin
        held_drive <= sat;
      end
    end
  end

  // held value goes out in the dead band or outside the error window
  always_ff @(posedge clk) begin
    if (ready_c && vb) begin
      m_axis_tdata    <= act_b ? sat : held_drive;
      m_axis_tuser[0] <= act_b;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pdiw_checker.sv
// pdiw_checker: port-level assertions for pid_deadband_integral_window
// depends on pdiw_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module pdiw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // requests accepted but not yet delivered
  logic [2:0] pending;
  logic [31:0] last_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_drive <= '0;
    end else begin
      pending <= pending + 3'(in_fire) - 3'(out_fire);
      if (out_fire) begin
        last_drive <= m_axis_tdata;
      end
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_drive: assert property (@(posedge clk) disable iff (rst)
    out_fire && !m_axis_tuser[0] |-> m_axis_tdata == last_drive)
    else $error("idle result does not repeat the last drive");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(pdiw_pkg::PipeDepth))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    pending == '0 |-> !m_axis_tvalid)
    else $error("result without a request");

endmodule

bind pid_deadband_integral_window pdiw_checker u_pdiw_checker (.*);

`default_nettype wire
